// ----- design/lbp_pkg.sv -----
`default_nettype none

package lbp_pkg;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_PERIOD_TICKS = 3'd0,
        CFG_DUTY_STEPS   = 3'd1,
        CFG_STEP_HOLD    = 3'd2,
        CFG_FULL_HOLD    = 3'd3,
        CFG_OFF_HOLD     = 3'd4
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LEN_W      = 16;
    localparam int DUTY_W     = 8;

    // Register reset values
    localparam logic [LEN_W-1:0]  PERIOD_TICKS_RST = 16'd2000;
    localparam logic [DUTY_W-1:0] DUTY_STEPS_RST   = 8'd100;
    localparam logic [LEN_W-1:0]  STEP_HOLD_RST    = 16'd9;
    localparam logic [LEN_W-1:0]  FULL_HOLD_RST    = 16'd125;
    localparam logic [LEN_W-1:0]  OFF_HOLD_RST     = 16'd125;

    // Breathing phases
    typedef enum logic [1:0] {
        PH_RAMP_UP   = 2'd0,
        PH_FULL_HOLD = 2'd1,
        PH_RAMP_DOWN = 2'd2,
        PH_OFF_HOLD  = 2'd3
    } t_phase;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic mul;
        logic eval;
    } t_cmd;

endpackage

`default_nettype wire

// ----- design/led_breathing_pwm.sv -----
`default_nettype none

// LED breathing PWM: each accepted item is one time tick (advance=1 moves time
// on, advance=0 pauses) and yields one result showing the LED level, duty step
// and phase of that tick before it advances. An item passes three steps
// (capture, product register, evaluate), and a new item is accepted only after
// the last one is evaluated; the evaluate step waits only while the output
// register still holds an untaken result. The on-time test uses two small
// registered multiplies (tick+1 times steps against period times duty) in place
// of a divider. Configuration writes are always ready and apply at once.
module led_breathing_pwm
    import lbp_pkg::*;
#(
    parameter int TIME_WIDTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire                  i_advance,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic                 o_led_on,
    output logic [DUTY_W-1:0]    o_duty_level,
    output logic [1:0]           o_phase
);

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    lbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    lbp_datapath #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_advance    (i_advance),
        .i_cmd        (w_cmd),
        .o_led_on     (o_led_on),
        .o_duty_level (o_duty_level),
        .o_phase      (o_phase)
    );

endmodule

`default_nettype wire

// ----- design/lbp_ctrl.sv -----
`default_nettype none

module lbp_ctrl
    import lbp_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_stall,
    output logic o_valid,
    input  wire  i_stall,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_EVAL = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    // Sequence one item: capture, form products, evaluate
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.mul     = 1'b0;
        o_cmd.eval    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EVAL;
            end
            S_EVAL: begin
                if (w_out_free) begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until it is taken
    always_comb begin
        if (o_cmd.eval) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- design/lbp_datapath.sv -----
`default_nettype none

module lbp_datapath
    import lbp_pkg::*;
#(
    parameter int TIME_WIDTH = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_valid,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                   i_advance,
    input  t_cmd                  i_cmd,
    output logic                  o_led_on,
    output logic [DUTY_W-1:0]     o_duty_level,
    output logic [1:0]            o_phase
);

    localparam int TW = TIME_WIDTH;
    localparam int LW = (TW > LEN_W) ? TW : LEN_W;
    localparam int PW = TW + 1 + DUTY_W;
    localparam logic [LW-1:0] TIME_MASK = LW'({TW{1'b1}});

    // Last count value of a length register, zero acting as one
    function automatic logic [TW-1:0] last_of(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] last;
        logic [LW-1:0]    ext;
        last = (len == '0) ? '0 : len - LEN_W'(1);
        ext  = LW'(last);
        if (ext > TIME_MASK) begin
            ext = TIME_MASK;
        end
        return TW'(ext);
    endfunction

    logic [LEN_W-1:0]  r_period;
    logic [DUTY_W-1:0] r_steps;
    logic [LEN_W-1:0]  r_step_hold;
    logic [LEN_W-1:0]  r_full_hold;
    logic [LEN_W-1:0]  r_off_hold;

    logic [TW-1:0]     r_tick, n_tick;
    logic [TW-1:0]     r_hold, n_hold;
    logic [DUTY_W-1:0] r_duty, n_duty;
    t_phase            r_phase, n_phase;

    logic              r_adv;
    logic [PW-1:0]     r_lhs;
    logic [PW-1:0]     r_rhs;
    logic              r_in_range;

    logic [TW-1:0]     w_per_last;
    logic [TW:0]       w_per;
    logic [TW:0]       w_tick_inc;
    logic [DUTY_W-1:0] w_steps;
    logic [TW-1:0]     w_hold_last;
    logic              w_led;

    // Write configuration registers, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_TICKS_RST;
            r_steps     <= DUTY_STEPS_RST;
            r_step_hold <= STEP_HOLD_RST;
            r_full_hold <= FULL_HOLD_RST;
            r_off_hold  <= OFF_HOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PERIOD_TICKS: r_period    <= i_cfg_data;
                CFG_DUTY_STEPS:   r_steps     <= i_cfg_data[DUTY_W-1:0];
                CFG_STEP_HOLD:    r_step_hold <= i_cfg_data;
                CFG_FULL_HOLD:    r_full_hold <= i_cfg_data;
                CFG_OFF_HOLD:     r_off_hold  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_per_last = last_of(r_period);
    assign w_per      = {1'b0, w_per_last} + (TW+1)'(1);
    assign w_tick_inc = {1'b0, r_tick} + (TW+1)'(1);
    assign w_steps    = (r_steps == '0) ? DUTY_W'(1) : r_steps;

    // Compare tick against on-time by cross products: tick+1 <= per*duty/steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_adv <= i_advance;
        end
        if (i_cmd.mul) begin
            r_lhs      <= PW'(w_tick_inc) * PW'(w_steps);
            r_rhs      <= PW'(w_per) * PW'(r_duty);
            r_in_range <= (r_tick <= w_per_last);
        end
    end

    assign w_led = r_in_range && (r_lhs <= r_rhs);

    // Select the hold length of the current phase
    always_comb begin
        case (r_phase)
            PH_FULL_HOLD: w_hold_last = last_of(r_full_hold);
            PH_OFF_HOLD:  w_hold_last = last_of(r_off_hold);
            default:      w_hold_last = last_of(r_step_hold);
        endcase
    end

    // Advance tick, period and level counters
    always_comb begin
        n_tick  = r_tick;
        n_hold  = r_hold;
        n_duty  = r_duty;
        n_phase = r_phase;
        if (r_adv) begin
            if (r_tick >= w_per_last) begin
                n_tick = '0;
                if (r_hold >= w_hold_last) begin
                    n_hold = '0;
                    case (r_phase)
                        PH_RAMP_UP: begin
                            if (r_duty >= w_steps) begin
                                n_phase = PH_FULL_HOLD;
                                n_duty  = w_steps;
                            end else begin
                                n_duty = r_duty + DUTY_W'(1);
                            end
                        end
                        PH_FULL_HOLD: begin
                            n_phase = PH_RAMP_DOWN;
                            n_duty  = w_steps - DUTY_W'(1);
                        end
                        PH_RAMP_DOWN: begin
                            if (r_duty == '0) begin
                                n_phase = PH_OFF_HOLD;
                            end else begin
                                n_duty = r_duty - DUTY_W'(1);
                            end
                        end
                        default: begin
                            n_phase = PH_RAMP_UP;
                            n_duty  = '0;
                        end
                    endcase
                end else begin
                    n_hold = r_hold + TW'(1);
                end
            end else begin
                n_tick = r_tick + TW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_hold  <= '0;
            r_duty  <= '0;
            r_phase <= PH_RAMP_UP;
        end else if (i_cmd.eval) begin
            r_tick  <= n_tick;
            r_hold  <= n_hold;
            r_duty  <= n_duty;
            r_phase <= n_phase;
        end
    end

    // Load the result register with the tick before the advance
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            o_led_on     <= w_led;
            o_duty_level <= r_duty;
            o_phase      <= r_phase;
        end
    end

endmodule

`default_nettype wire

// ----- design/lbp_checker.sv -----
`default_nettype none

module lbp_checker
    import lbp_pkg::*;
(
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_valid,
    input wire              o_stall,
    input wire              o_valid,
    input wire              i_stall,
    input wire              o_led_on,
    input wire [DUTY_W-1:0] o_duty_level,
    input wire [1:0]        o_phase
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_led_on)
            && $stable(o_duty_level) && $stable(o_phase))
        else $error("stalled result changed");

    // Take one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item accepted while busy");

    // Keep the LED dark at duty zero
    a_dark_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_led_on |-> o_duty_level != '0)
        else $error("LED lit at duty zero");

    // Show a nonzero level during full hold
    a_full_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_phase == PH_FULL_HOLD) |-> o_duty_level != '0)
        else $error("full hold with zero duty");

endmodule

bind led_breathing_pwm lbp_checker u_lbp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_led_on     (o_led_on),
    .o_duty_level (o_duty_level),
    .o_phase      (o_phase)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;
    import lbp_pkg::*;

    localparam int ITEMS_TOTAL   = 1400;
    localparam int CALM_ITEMS    = 200;
    localparam int STALL_LIMIT   = 1000;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;

    // One LED frame as the block shows it for a tick
    typedef struct {
        logic              led;
        logic [DUTY_W-1:0] level;
        t_phase            stage;
    } t_glow;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic                  i_advance   = 1'b0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic                  o_led_on;
    logic [DUTY_W-1:0]     o_duty_level;
    logic [1:0]            o_phase;

    led_breathing_pwm dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_advance    (i_advance),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_led_on     (o_led_on),
        .o_duty_level (o_duty_level),
        .o_phase      (o_phase)
    );

    // Register shadow
    logic [LEN_W-1:0]  reg_period;
    logic [DUTY_W-1:0] reg_steps;
    logic [LEN_W-1:0]  reg_step_hold;
    logic [LEN_W-1:0]  reg_full_hold;
    logic [LEN_W-1:0]  reg_off_hold;

    // Breathing state
    logic [LEN_W-1:0]  tick_pos;
    logic [LEN_W-1:0]  period_cnt;
    logic [DUTY_W-1:0] level;
    t_phase            stage;

    t_glow glow_q[$];
    int    items_sent  = 0;
    int    errors      = 0;
    int    idle_cycles = 0;
    int    stall_left  = 0;
    bit    calm        = 1'b0;

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Last count value of a length register; zero acts as one
    function automatic logic [LEN_W-1:0] last_count(input logic [LEN_W-1:0] len);
        return (len == '0) ? '0 : len - 1'b1;
    endfunction

    // Compute the frame shown for this tick, then advance the pattern
    task automatic breathe_step(input logic adv);
        logic [LEN_W-1:0]  per_last;
        logic [LEN_W-1:0]  hold_last;
        logic [DUTY_W-1:0] steps_e;
        int unsigned       per;
        int unsigned       on_time;
        t_glow             g;
        per_last = last_count(reg_period);
        per      = int'(per_last) + 1;
        steps_e  = (reg_steps == '0) ? 8'd1 : reg_steps;
        on_time  = (per * int'(level)) / int'(steps_e);
        if (on_time > per) on_time = per;
        g.led   = (int'(tick_pos) < on_time);
        g.level = level;
        g.stage = stage;
        glow_q.push_back(g);
        if (!adv) return;
        if (tick_pos < per_last) begin
            tick_pos = tick_pos + 1'b1;
            return;
        end
        tick_pos = '0;
        case (stage)
            PH_FULL_HOLD: hold_last = last_count(reg_full_hold);
            PH_OFF_HOLD:  hold_last = last_count(reg_off_hold);
            default:      hold_last = last_count(reg_step_hold);
        endcase
        if (period_cnt < hold_last) begin
            period_cnt = period_cnt + 1'b1;
            return;
        end
        period_cnt = '0;
        // Move to the next duty level or phase
        case (stage)
            PH_RAMP_UP: begin
                if (level >= steps_e) begin
                    stage = PH_FULL_HOLD;
                    level = steps_e;
                end else begin
                    level = level + 1'b1;
                end
            end
            PH_FULL_HOLD: begin
                stage = PH_RAMP_DOWN;
                level = steps_e - 1'b1;
            end
            PH_RAMP_DOWN: begin
                if (level == '0) stage = PH_OFF_HOLD;
                else level = level - 1'b1;
            end
            default: begin
                stage = PH_RAMP_UP;
                level = '0;
            end
        endcase
    endtask

    // Send one tick item; called and returns at a falling edge with valid low
    task automatic send_tick(input logic adv);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_advance = adv;
        do @(posedge i_clk); while (o_stall);
        breathe_step(adv);
        items_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Write one register and mirror it into the shadow
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PERIOD_TICKS: reg_period    = data;
            CFG_DUTY_STEPS:   reg_steps     = data[DUTY_W-1:0];
            CFG_STEP_HOLD:    reg_step_hold = data;
            CFG_FULL_HOLD:    reg_full_hold = data;
            CFG_OFF_HOLD:     reg_off_hold  = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drop valid and wait until every expected frame has come out
    task automatic settle();
        i_valid = 1'b0;
        while (glow_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly short lengths, sometimes zero, all ones or anything
    function automatic logic [LEN_W-1:0] pick_len(input int short_max);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return LEN_W'($urandom);
            default: return LEN_W'($urandom_range(1, short_max));
        endcase
    endfunction

    task automatic test_reset_values();
        send_tick(1'b0);
        send_tick(1'b1);
        settle();
    endtask

    // Zero lengths and steps act as one: every tick moves to a new level or phase
    task automatic test_zero_registers();
        cfg_write(CFG_PERIOD_TICKS, '0);
        cfg_write(CFG_DUTY_STEPS, '0);
        cfg_write(CFG_STEP_HOLD, '0);
        cfg_write(CFG_FULL_HOLD, '0);
        cfg_write(CFG_OFF_HOLD, '0);
        repeat (6) send_tick(1'b1);
        settle();
    endtask

    // Lower the step count below the current level during ramp up
    task automatic test_duty_over_steps();
        int guard;
        cfg_write(CFG_PERIOD_TICKS, 16'd1);
        cfg_write(CFG_DUTY_STEPS, 16'd8);
        cfg_write(CFG_STEP_HOLD, 16'd1);
        guard = 0;
        while (!(stage == PH_RAMP_UP && level >= 8'd5) && guard < 30) begin
            send_tick(1'b1);
            guard++;
        end
        settle();
        cfg_write(CFG_DUTY_STEPS, 16'h5a02);
        repeat (2) send_tick(1'b1);
        settle();
    endtask

    // Shorten the period while the tick counter sits past the new end
    task automatic test_counter_past_limit();
        cfg_write(CFG_PERIOD_TICKS, 16'd8);
        repeat (5) send_tick(1'b1);
        settle();
        cfg_write(CFG_PERIOD_TICKS, 16'd3);
        repeat (2) send_tick(1'b1);
        settle();
    endtask

    task automatic test_extreme_registers();
        cfg_write(CFG_PERIOD_TICKS, 16'hffff);
        cfg_write(CFG_DUTY_STEPS, 16'hffff);
        cfg_write(CFG_STEP_HOLD, 16'hffff);
        cfg_write(CFG_FULL_HOLD, 16'hffff);
        cfg_write(CFG_OFF_HOLD, 16'hffff);
        cfg_write(CFG_UNUSED_FIRST + 3'd2, 16'h0001);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        settle();
    endtask

    // Random settings, mostly short so whole breathing cycles run
    task automatic test_random_breathing();
        int run_len;
        logic [DUTY_W-1:0] steps;
        while (items_sent < ITEMS_TOTAL) begin
            settle();
            if ($urandom_range(0, 1)) cfg_write(CFG_PERIOD_TICKS, pick_len(6));
            if ($urandom_range(0, 1)) begin
                steps = ($urandom_range(0, 7) == 0) ? DUTY_W'($urandom)
                                                    : DUTY_W'($urandom_range(1, 6));
                cfg_write(CFG_DUTY_STEPS, {8'($urandom), steps});
            end
            if ($urandom_range(0, 1)) cfg_write(CFG_STEP_HOLD, pick_len(3));
            if ($urandom_range(0, 1)) cfg_write(CFG_FULL_HOLD, pick_len(3));
            if ($urandom_range(0, 1)) cfg_write(CFG_OFF_HOLD, pick_len(3));
            if ($urandom_range(0, 9) == 0)
                cfg_write(CFG_UNUSED_FIRST + 3'($urandom_range(0, 2)), 16'($urandom));
            if (items_sent >= ITEMS_TOTAL - CALM_ITEMS) calm = 1'b1;
            run_len = $urandom_range(20, 100);
            repeat (run_len) send_tick($urandom_range(0, 9) != 0);
        end
    endtask

    // Result side: random stall bursts, none in the calm part
    always @(negedge i_clk) begin
        if (calm) begin
            i_stall = 1'b0;
        end else if (stall_left != 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else if (!i_stall && $urandom_range(0, 7) == 0) begin
            i_stall = 1'b1;
            stall_left = $urandom_range(1, 14) - 1;
        end else begin
            i_stall = 1'b0;
        end
    end

    // Compare each taken result with the oldest expected frame
    always @(posedge i_clk) begin
        t_glow g;
        if (i_rst_n && o_valid && !i_stall) begin
            if (glow_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected frame: led=%0d level=%0d phase=%0d",
                             o_led_on, o_duty_level, o_phase);
            end else begin
                g = glow_q.pop_front();
                if (o_led_on !== g.led || o_duty_level !== g.level
                        || o_phase !== g.stage) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display({"frame mismatch: exp led=%0d level=%0d phase=%0d,",
                                  " got led=%0d level=%0d phase=%0d"},
                                 g.led, g.level, g.stage, o_led_on, o_duty_level,
                                 o_phase);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        reg_period    = PERIOD_TICKS_RST;
        reg_steps     = DUTY_STEPS_RST;
        reg_step_hold = STEP_HOLD_RST;
        reg_full_hold = FULL_HOLD_RST;
        reg_off_hold  = OFF_HOLD_RST;
        tick_pos      = '0;
        period_cnt    = '0;
        level         = '0;
        stage         = PH_RAMP_UP;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_zero_registers();
        test_duty_over_steps();
        test_counter_past_limit();
        test_extreme_registers();
        test_random_breathing();

        // Drain and let any stray frame show up
        settle();
        repeat (20) @(negedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
design/lbp_pkg.sv
design/lbp_ctrl.sv
design/lbp_datapath.sv
design/led_breathing_pwm.sv
design/lbp_checker.sv
tb/sv/testbench.sv
